// File: sv/assert_macros.svh
// Assertion macros used by the checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbp assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbp assertion failed");

`endif

// File: sv/sbp_pkg.sv
// Shared types, codes and helpers for the skewed branch predictor.
// No dependencies; imported by every predictor module and the checker.
package sbp_pkg;

    // Fixed field widths of the block's ports
    localparam int OP_W       = 3;
    localparam int PC_W       = 32;
    localparam int SNAP_W     = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CTR_W      = 2;

    // Default sizing
    localparam int DEF_COUNTER_ENTRIES   = 4096;
    localparam int DEF_HISTORY_BITS      = 16;
    localparam int DEF_DOUBLE_FIRST_BANK = 0;

    // Opcodes
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE     = 3'd1;
    localparam logic [OP_W-1:0] OP_SPEC_SHIFT = 3'd2;
    localparam logic [OP_W-1:0] OP_RECOVER    = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_UPDATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENHANCED_MODE  = 2'd2;

    // Reset values of configuration registers
    localparam logic [LEN_W-1:0] RST_HISTORY_LENGTH = 5'd8;

    // Counter encodings
    localparam logic [CTR_W-1:0] CTR_STRONG_NOT   = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_NOT     = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN   = 2'd2;
    localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN = 2'd3;

    // Saturating 2-bit counter step toward dir
    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                   input logic dir);
        logic [CTR_W-1:0] r;
        r = c;
        if (dir)
        begin
            if (c != CTR_STRONG_TAKEN)
            begin
                r = c + 1'b1;
            end
        end
        else
        begin
            if (c != CTR_STRONG_NOT)
            begin
                r = c - 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// File: sv/sbp_bank.sv
// One bank of 2-bit counters: single write port, registered read port.
// Forwards a write that lands on the address being read in the same cycle.
// Depends on sbp_pkg.
module sbp_bank
    import sbp_pkg::*;
#(
    parameter  int DEPTH = DEF_COUNTER_ENTRIES,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [CTR_W-1:0] wr_data,
    output logic [CTR_W-1:0] rd_data
);

    logic [CTR_W-1:0] mem [DEPTH];
    logic [CTR_W-1:0] rd_reg;
    logic [CTR_W-1:0] byp_data_reg;
    logic             byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read old data; take the colliding write's value instead
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg       <= mem[rd_idx];
            byp_hit_reg  <= wr_en && (wr_idx == rd_idx);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_reg;

endmodule

// File: sv/sbp_hash.sv
// Skewing hash: three counter indices from the pc placed above a history value.
// Depends on sbp_pkg.
module sbp_hash
    import sbp_pkg::*;
#(
    parameter  int COUNTER_ENTRIES   = DEF_COUNTER_ENTRIES,
    parameter  int HISTORY_BITS      = DEF_HISTORY_BITS,
    parameter  int DOUBLE_FIRST_BANK = DEF_DOUBLE_FIRST_BANK,
    localparam int IDX_W             = $clog2(COUNTER_ENTRIES),
    localparam int IDX0_W            = IDX_W + DOUBLE_FIRST_BANK
)
(
    input  logic [PC_W-1:0]         pc,
    input  logic [HISTORY_BITS-1:0] hist,
    input  logic [LEN_W-1:0]        eff_len,
    input  logic                    enhanced,
    output logic [IDX0_W-1:0]       idx0,
    output logic [IDX_W-1:0]        idx1,
    output logic [IDX_W-1:0]        idx2
);

    localparam int BASE_W = PC_W + HISTORY_BITS;

    logic [BASE_W-1:0] base;
    logic [IDX_W-1:0]  v1;
    logic [IDX_W-1:0]  v2;
    logic [IDX_W-1:0]  h_v1;
    logic [IDX_W-1:0]  h_v2;
    logic [IDX_W:0]    hi_v1;
    logic [IDX_W:0]    hi_v2;
    logic [IDX_W:0]    sk0;

    always_comb
    begin
        base  = (BASE_W'(pc) << eff_len) | BASE_W'(hist);
        v1    = base[IDX_W-1:0];
        v2    = base[2*IDX_W-1:IDX_W];
        // forward skew: rotate right, top bit picks up the xor of the ends
        h_v1  = {v1[IDX_W-1] ^ v1[0], v1[IDX_W-1:1]};
        h_v2  = {v2[IDX_W-1] ^ v2[0], v2[IDX_W-1:1]};
        // inverse skew keeps the shifted-out top bit for the wide first bank
        hi_v1 = {v1, v1[IDX_W-1] ^ v1[IDX_W-2]};
        hi_v2 = {v2, v2[IDX_W-1] ^ v2[IDX_W-2]};
        sk0   = {1'b0, h_v1} ^ hi_v2 ^ {1'b0, v2};
        idx0  = enhanced ? pc[IDX0_W-1:0] : sk0[IDX0_W-1:0];
        idx1  = h_v1 ^ hi_v2[IDX_W-1:0] ^ v1;
        idx2  = h_v2 ^ hi_v1[IDX_W-1:0] ^ v2;
    end

endmodule

// File: sv/skewed_branch_predictor_top.sv
// Skewed branch direction predictor: three banks of 2-bit counters, majority vote.
// Accepted beats pass stage 1, stage 2 and the result register to done; one item
// per clock while busy is low, fixed by the single read and write port per bank.
// Reset: busy stays high for one pass over bank 0 (COUNTER_ENTRIES cycles, twice that
// with the doubled first bank) while counters load their initial values.
// Results cannot be stalled by the receiver. Depends on sbp_pkg, sbp_hash, sbp_bank.
module skewed_branch_predictor_top
    import sbp_pkg::*;
#(
    parameter int COUNTER_ENTRIES   = DEF_COUNTER_ENTRIES,
    parameter int HISTORY_BITS      = DEF_HISTORY_BITS,
    parameter int DOUBLE_FIRST_BANK = DEF_DOUBLE_FIRST_BANK
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       opcode,
    input  logic [PC_W-1:0]       pc,
    input  logic [SNAP_W-1:0]     lookup_history,
    input  logic                  lookup_pred,
    input  logic                  outcome,
    input  logic                  spec_dir,
    output logic                  done,
    output logic                  taken,
    output logic [SNAP_W-1:0]     history_used,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W         = $clog2(COUNTER_ENTRIES);
    localparam int IDX0_W        = IDX_W + DOUBLE_FIRST_BANK;
    localparam int BANK0_ENTRIES = COUNTER_ENTRIES * (1 + DOUBLE_FIRST_BANK);
    localparam int MASK_W        = HISTORY_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] hist_len_reg;
    logic             partial_reg;
    logic             enhanced_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_len_reg <= RST_HISTORY_LENGTH;
            partial_reg  <= 1'b0;
            enhanced_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HISTORY_LENGTH: hist_len_reg <= cfg_data[LEN_W-1:0];
                REG_PARTIAL_UPDATE: partial_reg  <= cfg_data[0];
                REG_ENHANCED_MODE:  enhanced_reg <= cfg_data[0];
                default:            ; // unused index: drop the write
            endcase
        end
    end

    // Effective history length, clamped to the register width
    logic [LEN_W-1:0]        eff_len;
    logic [MASK_W-1:0]       hmask_w;
    logic [HISTORY_BITS-1:0] hmask;

    assign eff_len = ({1'b0, hist_len_reg} > (LEN_W+1)'(HISTORY_BITS))
                   ? LEN_W'(HISTORY_BITS) : hist_len_reg;
    assign hmask_w = (MASK_W'(1) << eff_len) - MASK_W'(1);
    assign hmask   = hmask_w[HISTORY_BITS-1:0];

    // ------------------------------------------------------------------
    // Counter initialization sweep after reset
    // ------------------------------------------------------------------
    logic              clr_busy_reg;
    logic [IDX0_W-1:0] clr_idx_reg;
    logic              clr_in_small;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX0_W'(BANK0_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Banks one and two are only as deep as COUNTER_ENTRIES
    assign clr_in_small = ({1'b0, clr_idx_reg} < (IDX0_W+1)'(COUNTER_ENTRIES));
    assign busy         = clr_busy_reg;

    // ------------------------------------------------------------------
    // Stage 1: input register, hashing, history update, bank read
    // ------------------------------------------------------------------
    logic                    accept;
    logic                    s1_vld_reg;
    logic [OP_W-1:0]         s1_op_reg;
    logic [PC_W-1:0]         s1_pc_reg;
    logic [HISTORY_BITS-1:0] s1_snap_reg;
    logic                    s1_lpred_reg;
    logic                    s1_outc_reg;
    logic                    s1_sdir_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= opcode;
            s1_pc_reg    <= pc;
            s1_snap_reg  <= HISTORY_BITS'(lookup_history);
            s1_lpred_reg <= lookup_pred;
            s1_outc_reg  <= outcome;
            s1_sdir_reg  <= spec_dir;
        end
    end

    // Global history register: one entry, so recover and flush always apply
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;

    always_comb
    begin
        hist_next = hist_reg;
        if (s1_vld_reg)
        begin
            unique case (s1_op_reg)
                OP_SPEC_SHIFT: hist_next = HISTORY_BITS'({hist_reg, s1_sdir_reg}) & hmask;
                OP_RECOVER:    hist_next = HISTORY_BITS'({s1_snap_reg, s1_outc_reg}) & hmask;
                OP_FLUSH:      hist_next = s1_snap_reg;
                default:       hist_next = hist_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // Lookup hashes with the live history, update with the snapshot
    logic [HISTORY_BITS-1:0] hash_hist;
    logic [IDX0_W-1:0]       s1_idx0;
    logic [IDX_W-1:0]        s1_idx1;
    logic [IDX_W-1:0]        s1_idx2;

    assign hash_hist = (s1_op_reg == OP_LOOKUP) ? hist_reg : s1_snap_reg;

    sbp_hash #(
        .COUNTER_ENTRIES   (COUNTER_ENTRIES),
        .HISTORY_BITS      (HISTORY_BITS),
        .DOUBLE_FIRST_BANK (DOUBLE_FIRST_BANK)
    ) u_hash (
        .pc       (s1_pc_reg),
        .hist     (hash_hist),
        .eff_len  (eff_len),
        .enhanced (enhanced_reg),
        .idx0     (s1_idx0),
        .idx1     (s1_idx1),
        .idx2     (s1_idx2)
    );

    // ------------------------------------------------------------------
    // Stage 2: vote or train
    // ------------------------------------------------------------------
    logic                s2_vld_reg;
    logic [OP_W-1:0]     s2_op_reg;
    logic                s2_lpred_reg;
    logic                s2_outc_reg;
    logic [SNAP_W-1:0]   s2_hist_reg;
    logic [IDX0_W-1:0]   s2_idx0_reg;
    logic [IDX_W-1:0]    s2_idx1_reg;
    logic [IDX_W-1:0]    s2_idx2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_lpred_reg <= s1_lpred_reg;
            s2_outc_reg  <= s1_outc_reg;
            s2_hist_reg  <= SNAP_W'(hist_reg);
            s2_idx0_reg  <= s1_idx0;
            s2_idx1_reg  <= s1_idx1;
            s2_idx2_reg  <= s1_idx2;
        end
    end

    logic [CTR_W-1:0] ctr0;
    logic [CTR_W-1:0] ctr1;
    logic [CTR_W-1:0] ctr2;
    logic             is_update;
    logic             train_all;
    logic             trn0;
    logic             trn1;
    logic             trn2;
    logic             vote;

    // On a correct guess with partial update, train only agreeing banks
    assign is_update = s2_vld_reg && (s2_op_reg == OP_UPDATE);
    assign train_all = !((s2_lpred_reg == s2_outc_reg) && partial_reg);
    assign trn0      = is_update && (train_all || (ctr0[CTR_W-1] == s2_outc_reg));
    assign trn1      = is_update && (train_all || (ctr1[CTR_W-1] == s2_outc_reg));
    assign trn2      = is_update && (train_all || (ctr2[CTR_W-1] == s2_outc_reg));
    assign vote      = (ctr0[CTR_W-1] & ctr1[CTR_W-1]) | (ctr0[CTR_W-1] & ctr2[CTR_W-1])
                     | (ctr1[CTR_W-1] & ctr2[CTR_W-1]);

    // Bank write ports: init sweep first, then training writes
    logic              wr0_en;
    logic              wr1_en;
    logic              wr2_en;
    logic [IDX0_W-1:0] wr0_idx;
    logic [IDX_W-1:0]  wr1_idx;
    logic [IDX_W-1:0]  wr2_idx;
    logic [CTR_W-1:0]  wr0_data;
    logic [CTR_W-1:0]  wr1_data;
    logic [CTR_W-1:0]  wr2_data;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            // odd entries weakly taken in banks zero and two, even ones in bank one
            wr0_en   = 1'b1;
            wr1_en   = clr_in_small;
            wr2_en   = clr_in_small;
            wr0_idx  = clr_idx_reg;
            wr1_idx  = clr_idx_reg[IDX_W-1:0];
            wr2_idx  = clr_idx_reg[IDX_W-1:0];
            wr0_data = clr_idx_reg[0] ? CTR_WEAK_TAKEN : CTR_WEAK_NOT;
            wr1_data = clr_idx_reg[0] ? CTR_WEAK_NOT : CTR_WEAK_TAKEN;
            wr2_data = clr_idx_reg[0] ? CTR_WEAK_TAKEN : CTR_WEAK_NOT;
        end
        else
        begin
            wr0_en   = trn0;
            wr1_en   = trn1;
            wr2_en   = trn2;
            wr0_idx  = s2_idx0_reg;
            wr1_idx  = s2_idx1_reg;
            wr2_idx  = s2_idx2_reg;
            wr0_data = ctr_train(ctr0, s2_outc_reg);
            wr1_data = ctr_train(ctr1, s2_outc_reg);
            wr2_data = ctr_train(ctr2, s2_outc_reg);
        end
    end

    sbp_bank #(.DEPTH(BANK0_ENTRIES)) u_bank0 (
        .clk     (clk),
        .rd_en   (s1_vld_reg),
        .rd_idx  (s1_idx0),
        .wr_en   (wr0_en),
        .wr_idx  (wr0_idx),
        .wr_data (wr0_data),
        .rd_data (ctr0)
    );

    sbp_bank #(.DEPTH(COUNTER_ENTRIES)) u_bank1 (
        .clk     (clk),
        .rd_en   (s1_vld_reg),
        .rd_idx  (s1_idx1),
        .wr_en   (wr1_en),
        .wr_idx  (wr1_idx),
        .wr_data (wr1_data),
        .rd_data (ctr1)
    );

    sbp_bank #(.DEPTH(COUNTER_ENTRIES)) u_bank2 (
        .clk     (clk),
        .rd_en   (s1_vld_reg),
        .rd_idx  (s1_idx2),
        .wr_en   (wr2_en),
        .wr_idx  (wr2_idx),
        .wr_data (wr2_data),
        .rd_data (ctr2)
    );

    // ------------------------------------------------------------------
    // Result register: one beat per item, zero fields unless lookup
    // ------------------------------------------------------------------
    logic              done_reg;
    logic              taken_reg;
    logic [SNAP_W-1:0] hist_used_reg;
    logic              is_lookup;

    assign is_lookup = s2_vld_reg && (s2_op_reg == OP_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            taken_reg     <= 1'b0;
            hist_used_reg <= '0;
        end
        else
        begin
            done_reg      <= s2_vld_reg;
            taken_reg     <= is_lookup && vote;
            hist_used_reg <= is_lookup ? s2_hist_reg : '0;
        end
    end

    assign done         = done_reg;
    assign taken        = taken_reg;
    assign history_used = hist_used_reg;

endmodule

// File: sv/sbp_checker.sv
// Port-level checker for the skewed branch predictor, bound to the top level.
// Depends on sbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbp_checker
    import sbp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              taken,
    input logic [SNAP_W-1:0] history_used
);

    // Every accepted beat produces exactly one result beat on done
    `SBP_ASSERT_IMP(a_done_follows_accept, start && !busy, ##3 done)
    `SBP_ASSERT_IMP(a_done_has_source, done, $past(start && !busy, 3))
    // Result fields stay quiet between beats
    `SBP_ASSERT_IMP(a_idle_fields_zero, !done, !taken && (history_used == '0))
    // Init sweep runs once after reset
    `SBP_ASSERT_NXT(a_busy_stays_low, !busy, !busy)

endmodule

bind skewed_branch_predictor_top sbp_checker u_sbp_checker (.*);

// File: dv/skewed_branch_predictor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for skewed_branch_predictor_top: directed and random command beats,
// checked against an in-bench model of the three counter banks and the history register.
// Depends on sbp_pkg and the predictor RTL only.
module skewed_branch_predictor_top_tb;
    import sbp_pkg::*;

    // Bench sizing: the block runs with its default parameters
    localparam int IDX_W = $clog2(DEF_COUNTER_ENTRIES);
    localparam logic [63:0] SLOT_MASK = 64'(DEF_COUNTER_ENTRIES - 1);
    localparam logic [63:0] SKEW_TOP  = 64'(DEF_COUNTER_ENTRIES / 2);
    localparam int HOT_PCS     = 16;
    localparam int CYCLE_LIMIT = 200000;

    // Opcodes the block must ignore, and the register index it has no register for
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One command beat as presented on the input ports
    typedef struct {
        logic [OP_W-1:0]   opcode;
        logic [PC_W-1:0]   pc;
        logic [SNAP_W-1:0] snap;
        logic              lpred;
        logic              outc;
        logic              sdir;
    } branch_op_t;

    // One result beat: prediction and history read, plus the opcode for messages
    typedef struct {
        logic              taken;
        logic [SNAP_W-1:0] hist;
        logic [OP_W-1:0]   opcode;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       opcode = OP_LOOKUP;
    logic [PC_W-1:0]       pc = '0;
    logic [SNAP_W-1:0]     lookup_history = '0;
    logic                  lookup_pred = 1'b0;
    logic                  outcome = 1'b0;
    logic                  spec_dir = 1'b0;
    logic                  done;
    logic                  taken;
    logic [SNAP_W-1:0]     history_used;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_HISTORY_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    skewed_branch_predictor_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .pc             (pc),
        .lookup_history (lookup_history),
        .lookup_pred    (lookup_pred),
        .outcome        (outcome),
        .spec_dir       (spec_dir),
        .done           (done),
        .taken          (taken),
        .history_used   (history_used),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Model state: the global history, the three counter banks and
    // the shadow of the configuration registers.
    // ---------------------------------------------------------------
    logic [SNAP_W-1:0] ghist;
    logic [CTR_W-1:0]  ctr_bank0 [DEF_COUNTER_ENTRIES];
    logic [CTR_W-1:0]  ctr_bank1 [DEF_COUNTER_ENTRIES];
    logic [CTR_W-1:0]  ctr_bank2 [DEF_COUNTER_ENTRIES];
    logic [LEN_W-1:0]  cfg_hist_len;
    logic              cfg_partial;
    logic              cfg_enhanced;

    branch_op_t pending_ops [$];       // beats waiting for the driver
    verdict_t   expected_verdicts [$]; // predictions waiting for their result beat
    branch_op_t seen_lookups [$];      // recent lookups with the history they returned
    branch_op_t on_port;               // beat currently held on the input ports
    logic [PC_W-1:0] hot_pcs [HOT_PCS];
    bit  hold_steady = 1'b0;           // set: driver never idles at random
    int  mismatches = 0;
    int  cycle_count = 0;

    // Bring the model to its post-reset contents
    task automatic reset_model();
        ghist        = '0;
        cfg_hist_len = RST_HISTORY_LENGTH;
        cfg_partial  = 1'b0;
        cfg_enhanced = 1'b0;
        for (int i = 0; i < DEF_COUNTER_ENTRIES; i++)
        begin
            ctr_bank0[i] = (i % 2) ? CTR_WEAK_TAKEN : CTR_WEAK_NOT;
            ctr_bank1[i] = (i % 2) ? CTR_WEAK_NOT : CTR_WEAK_TAKEN;
            ctr_bank2[i] = (i % 2) ? CTR_WEAK_TAKEN : CTR_WEAK_NOT;
        end
    endtask

    // History lengths past the register width behave as the full width
    function automatic int kept_len();
        return (cfg_hist_len > DEF_HISTORY_BITS) ? DEF_HISTORY_BITS : int'(cfg_hist_len);
    endfunction

    // Skewing function and its inverse over IDX_W-bit values
    function automatic logic [63:0] skew_fwd(input logic [63:0] v);
        return (v >> 1) | ((v & SKEW_TOP) ^ ((v & 64'd1) << (IDX_W - 1)));
    endfunction

    function automatic logic [63:0] skew_back(input logic [63:0] v);
        return (v << 1) | (((v & SKEW_TOP) ^ ((v & (SKEW_TOP >> 1)) << 1)) >> (IDX_W - 1));
    endfunction

    // Three bank slots from the pc placed above the history; the history is
    // OR-ed in, not masked, so bits above the kept length overlap the pc.
    function automatic void hash_slots(input logic [PC_W-1:0] br_pc,
                                       input logic [SNAP_W-1:0] hist,
                                       output logic [IDX_W-1:0] s0,
                                       output logic [IDX_W-1:0] s1,
                                       output logic [IDX_W-1:0] s2);
        logic [63:0] base;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] t2;
        base = ({32'd0, br_pc} << kept_len()) | {48'd0, hist};
        v1 = base & SLOT_MASK;
        v2 = (base >> IDX_W) & SLOT_MASK;
        t0 = (skew_fwd(v1) ^ skew_back(v2) ^ v2) & SLOT_MASK;
        t1 = (skew_fwd(v1) ^ skew_back(v2) ^ v1) & SLOT_MASK;
        t2 = (skew_fwd(v2) ^ skew_back(v1) ^ v2) & SLOT_MASK;
        s0 = cfg_enhanced ? br_pc[IDX_W-1:0] : t0[IDX_W-1:0];
        s1 = t1[IDX_W-1:0];
        s2 = t2[IDX_W-1:0];
    endfunction

    // Saturating step of a 2-bit counter toward dir
    function automatic logic [CTR_W-1:0] nudge(input logic [CTR_W-1:0] c, input logic dir);
        if (dir)
        begin
            return (c == CTR_STRONG_TAKEN) ? c : c + 1'b1;
        end
        return (c == CTR_STRONG_NOT) ? c : c - 1'b1;
    endfunction

    // Advance the model by one accepted beat and return the result it must produce
    function automatic verdict_t predict_branch(input branch_op_t b);
        verdict_t    v;
        logic [IDX_W-1:0] s0;
        logic [IDX_W-1:0] s1;
        logic [IDX_W-1:0] s2;
        logic [63:0] wide_mask;
        logic [SNAP_W-1:0] keep;
        logic        only_agree;
        int          votes;
        v.taken   = 1'b0;
        v.hist    = '0;
        v.opcode  = b.opcode;
        wide_mask = (64'd1 << kept_len()) - 64'd1;
        keep      = wide_mask[SNAP_W-1:0];
        case (b.opcode)
            OP_LOOKUP:
            begin
                // lookup reads the register as it is, not cut to the kept length
                hash_slots(b.pc, ghist, s0, s1, s2);
                votes = int'(ctr_bank0[s0][1]) + int'(ctr_bank1[s1][1])
                      + int'(ctr_bank2[s2][1]);
                v.taken = (votes >= 2);
                v.hist  = ghist;
            end
            OP_UPDATE:
            begin
                // on a correct guess with partial update, train only banks that agreed
                hash_slots(b.pc, b.snap, s0, s1, s2);
                only_agree = cfg_partial && (b.lpred == b.outc);
                if (!only_agree || ctr_bank0[s0][1] == b.outc)
                    ctr_bank0[s0] = nudge(ctr_bank0[s0], b.outc);
                if (!only_agree || ctr_bank1[s1][1] == b.outc)
                    ctr_bank1[s1] = nudge(ctr_bank1[s1], b.outc);
                if (!only_agree || ctr_bank2[s2][1] == b.outc)
                    ctr_bank2[s2] = nudge(ctr_bank2[s2], b.outc);
            end
            OP_SPEC_SHIFT: ghist = {ghist[SNAP_W-2:0], b.sdir} & keep;
            OP_RECOVER:    ghist = {b.snap[SNAP_W-2:0], b.outc} & keep;
            OP_FLUSH:      ghist = b.snap;
            default:       ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Driver: hold the current beat until start && !busy, then predict
    // it and either advance to the next pending beat or drop start.
    // Idle at random unless hold_steady is set.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_beat
        verdict_t   v;
        branch_op_t rec;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                v = predict_branch(on_port);
                expected_verdicts.push_back(v);
                // remember lookups so later updates carry a real snapshot
                if (on_port.opcode == OP_LOOKUP)
                begin
                    rec       = on_port;
                    rec.snap  = v.hist;
                    rec.lpred = v.taken;
                    seen_lookups.push_back(rec);
                    if (seen_lookups.size() > 24)
                        void'(seen_lookups.pop_front());
                end
            end
            if (!start || !busy)
            begin
                if (pending_ops.size() != 0 && (hold_steady || $urandom_range(99) >= 15))
                begin
                    on_port        = pending_ops.pop_front();
                    start          <= 1'b1;
                    opcode         <= on_port.opcode;
                    pc             <= on_port.pc;
                    lookup_history <= on_port.snap;
                    lookup_pred    <= on_port.lpred;
                    outcome        <= on_port.outc;
                    spec_dir       <= on_port.sdir;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every done beat must match the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_beat
        verdict_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("result beat with no command outstanding");
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (taken !== want.taken)
                    report_mismatch($sformatf("op %0d taken got %b want %b",
                                              want.opcode, taken, want.taken));
                if (history_used !== want.hist)
                    report_mismatch($sformatf("op %0d history_used got %h want %h",
                                              want.opcode, history_used, want.hist));
            end
        end
    end

    // Watchdog: end a run that stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic enqueue(input logic [OP_W-1:0] op, input logic [PC_W-1:0] br_pc,
                           input logic [SNAP_W-1:0] snap, input logic lp, oc, sd);
        branch_op_t b;
        b.opcode = op;
        b.pc     = br_pc;
        b.snap   = snap;
        b.lpred  = lp;
        b.outc   = oc;
        b.sdir   = sd;
        pending_ops.push_back(b);
    endtask

    // Wait until every beat is sent and answered, then let the pipe settle
    task automatic wait_quiet();
        do @(negedge clk);
        while (pending_ops.size() != 0 || start || expected_verdicts.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_HISTORY_LENGTH: cfg_hist_len = val;
            REG_PARTIAL_UPDATE: cfg_partial  = val[0];
            REG_ENHANCED_MODE:  cfg_enhanced = val[0];
            default:            ;
        endcase
    endtask

    // Write all registers once the block is idle; the spare index must change nothing
    task automatic apply_setting(input logic [LEN_W-1:0] len, input logic part, input logic enh);
        wait_quiet();
        write_reg(REG_HISTORY_LENGTH, len);
        write_reg(REG_PARTIAL_UPDATE, part);
        write_reg(REG_ENHANCED_MODE, enh);
        write_reg(REG_SPARE, $urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly lookup/shift pairs and updates that replay a real
    // lookup (some mispredicted, some followed by recover), plus flushes and noise.
    task automatic run_traffic(input int count);
        int made;
        int pick;
        branch_op_t rec;
        logic [PC_W-1:0] br_pc;
        logic [OP_W-1:0] op;
        logic oc;
        made = 0;
        while (made < count)
        begin
            do @(negedge clk);
            while (pending_ops.size() >= 4);
            pick  = $urandom_range(99);
            br_pc = ($urandom_range(7) == 0) ? $urandom() : hot_pcs[$urandom_range(HOT_PCS - 1)];
            if (seen_lookups.size() != 0)
                rec = seen_lookups[$urandom_range(seen_lookups.size() - 1)];
            if (pick < 40 || seen_lookups.size() == 0)
            begin
                enqueue(OP_LOOKUP, br_pc, $urandom(), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
                enqueue(OP_SPEC_SHIFT, br_pc, $urandom(), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
                made += 2;
            end
            else if (pick < 75)
            begin
                oc = ($urandom_range(9) < 7) ? rec.lpred : !rec.lpred;
                enqueue(OP_UPDATE, rec.pc, rec.snap, rec.lpred, oc, $urandom_range(1));
                made++;
                if (oc != rec.lpred && $urandom_range(1))
                begin
                    enqueue(OP_RECOVER, rec.pc, rec.snap, rec.lpred, oc, $urandom_range(1));
                    made++;
                end
            end
            else if (pick < 83)
            begin
                enqueue(OP_FLUSH, $urandom(), rec.snap, $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
                made++;
            end
            else
            begin
                op = $urandom_range(7);
                enqueue(op, $urandom(), $urandom(), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
                if (op <= OP_FLUSH)
                    made++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus: reset, directed beats at a few settings, then random
    // phases over a range of settings including the extremes.
    // ---------------------------------------------------------------
    initial
    begin
        int               phase_len [7];
        logic [LEN_W-1:0] phase_hlen [7];
        logic             phase_part [7];
        logic             phase_enh [7];
        phase_len  = '{200, 250, 250, 250, 250, 200, 150};
        phase_hlen = '{5'd0, 5'd16, 5'd5, 5'd31, 5'd12, 5'd17, 5'd0};
        phase_part = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        phase_enh  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        reset_model();
        foreach (hot_pcs[i])
            hot_pcs[i] = $urandom();

        // Hold reset, then release it; the block then clears its banks while busy
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at reset settings: pc extremes, shifts, training both ways,
        // recover masked to the kept length, flush left unmasked and read back by a
        // lookup, and the three unused opcodes.
        enqueue(OP_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        enqueue(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        enqueue(OP_SPEC_SHIFT, $urandom(), $urandom(), 1'b0, 1'b1, 1'b1);
        enqueue(OP_SPEC_SHIFT, $urandom(), $urandom(), 1'b1, 1'b0, 1'b1);
        enqueue(OP_LOOKUP, $urandom(), $urandom(), 1'b0, 1'b0, 1'b0);
        enqueue(OP_UPDATE, $urandom(), 16'hFFFF, 1'b1, 1'b1, 1'b0);
        enqueue(OP_UPDATE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        enqueue(OP_RECOVER, $urandom(), 16'hFFFF, 1'b0, 1'b1, 1'b0);
        enqueue(OP_LOOKUP, $urandom(), $urandom(), 1'b1, 1'b0, 1'b1);
        enqueue(OP_FLUSH, $urandom(), 16'hFFFF, 1'b0, 1'b0, 1'b0);
        enqueue(OP_LOOKUP, 32'hFFFF_FFFF, $urandom(), 1'b0, 1'b1, 1'b0);
        enqueue(OP_SPEC_SHIFT, $urandom(), $urandom(), 1'b1, 1'b1, 1'b0);
        enqueue(OP_RSVD_5, $urandom(), $urandom(), 1'b1, 1'b1, 1'b1);
        enqueue(OP_RSVD_6, $urandom(), $urandom(), 1'b0, 1'b1, 1'b0);
        enqueue(OP_RSVD_7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        enqueue(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);

        // Over-long history with partial update and the bimodal first bank
        apply_setting(5'd31, 1'b1, 1'b1);
        enqueue(OP_FLUSH, $urandom(), 16'hFFFF, 1'b0, 1'b0, 1'b0);
        enqueue(OP_SPEC_SHIFT, $urandom(), $urandom(), 1'b0, 1'b0, 1'b0);
        enqueue(OP_LOOKUP, 32'hFFFF_FFFF, $urandom(), 1'b0, 1'b0, 1'b0);
        enqueue(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFE, 1'b1, 1'b1, 1'b0);
        enqueue(OP_RECOVER, $urandom(), 16'h8000, 1'b0, 1'b1, 1'b0);
        enqueue(OP_LOOKUP, $urandom(), $urandom(), 1'b0, 1'b0, 1'b0);

        // Zero history length: shift and recover must leave the history empty
        apply_setting(5'd0, 1'b0, 1'b0);
        enqueue(OP_SPEC_SHIFT, $urandom(), $urandom(), 1'b0, 1'b0, 1'b1);
        enqueue(OP_RECOVER, $urandom(), 16'hFFFF, 1'b0, 1'b1, 1'b0);
        enqueue(OP_LOOKUP, $urandom(), $urandom(), 1'b0, 1'b0, 1'b0);

        // Random phases; the last one draws its own setting
        phase_hlen[6] = $urandom_range(31);
        phase_part[6] = $urandom_range(1);
        phase_enh[6]  = $urandom_range(1);
        for (int p = 0; p < 7; p++)
        begin
            apply_setting(phase_hlen[p], phase_part[p], phase_enh[p]);
            hold_steady = (p == 1);
            run_traffic(phase_len[p]);
        end
        hold_steady = 1'b0;

        // Drain, allow the pipe latency, then give the verdict
        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
